FILE: src/pts_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pts_pkg
// Shared types and codes of the priority tick task scheduler.
// ----------------------------------------------------------------------------
package pts_pkg;

	localparam int ID_W       = 4;
	localparam int LAP_W      = 8;
	localparam int PRI_W      = 8;
	localparam int CNT_W      = 8;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;
	localparam int RESULT_CAP = 8;
	localparam int REPORT_W   = 4;

	localparam logic [1:0] REQ_TICK   = 2'd0;
	localparam logic [1:0] REQ_CREATE = 2'd1;
	localparam logic [1:0] REQ_DELETE = 2'd2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NOT_INIT = 2'd1;
	localparam logic [1:0] ST_INVALID  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_ENABLED  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TICK_RES = 1'd1;

	typedef struct packed {
		logic [ID_W-1:0]  id;
		logic [CNT_W-1:0] fire_count;
		logic [CNT_W-1:0] tick_count;
		logic [PRI_W-1:0] priority_val;
		logic             single_run;
	} entry_t;

endpackage
`default_nettype wire

FILE: src/pts_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pts_if
// Request, result and register write channels of the scheduler.
// ----------------------------------------------------------------------------
interface pts_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] req_type;
	logic [3:0] task_id;
	logic [7:0] period_ms;
	logic       single_run;
	logic [7:0] priority_req;

	modport source (output valid, req_type, task_id, period_ms, single_run, priority_req,
		input ready);
	modport sink (input valid, req_type, task_id, period_ms, single_run, priority_req,
		output ready);
endinterface

interface pts_res_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic       fired;
	logic [3:0] fired_task_id;
	logic       last;

	modport source (output valid, status, fired, fired_task_id, last, input ready);
	modport sink (input valid, status, fired, fired_task_id, last, output ready);
endinterface

interface pts_cfg_if;
	logic       valid;
	logic       ready;
	logic [0:0] index;
	logic [7:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: src/pts_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pts_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module pts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	parameter int AW    = 3
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

FILE: src/pts_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pts_div
// Restoring divider, one quotient bit per cycle, for lap time over resolution.
// ----------------------------------------------------------------------------
module pts_div (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [pts_pkg::LAP_W-1:0] dividend,
	input  wire logic [pts_pkg::LAP_W-1:0] divisor,
	output logic                           done,
	output logic      [pts_pkg::LAP_W-1:0] quotient,
	output logic      [pts_pkg::LAP_W-1:0] remainder
);
	import pts_pkg::*;

	localparam int STEP_W = $clog2(LAP_W);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [LAP_W-1:0]  quot_q;
	logic [LAP_W-1:0]  rem_q;
	logic [LAP_W:0]    shifted;
	logic [LAP_W:0]    diff;
	logic              ge;

	always_comb begin
		shifted = {rem_q, quot_q[LAP_W-1]};
		ge      = shifted >= {1'b0, divisor};
		diff    = shifted - {1'b0, divisor};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(LAP_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend;
			rem_q  <= '0;
		end else if (busy_q) begin
			quot_q <= {quot_q[LAP_W-2:0], ge};
			rem_q  <= ge ? diff[LAP_W-1:0] : shifted[LAP_W-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quot_q;
	assign remainder = rem_q;

endmodule
`default_nettype wire

FILE: src/priority_tick_task_scheduler_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// priority_tick_task_scheduler_unit
// Priority ordered task timer table kept in a RAM, walked one entry a cycle.
// ----------------------------------------------------------------------------
// create: the 8 step divider, then, unless rejected, a compare walk and a write
// delete and a tick with a scheduler step walk every entry in the table
// other ticks and rejected requests go straight to the result
// output stalls delay all of these, and a tick walk waits on a full result output
// one request in work at a time; the next is taken the cycle after the last result
// reset empties the table, clears the id map and prescaler, disables the unit
// ----------------------------------------------------------------------------
module priority_tick_task_scheduler_unit #(
	parameter int TABLE_SIZE = 8,
	parameter int MAX_LAP    = 255
) (
	input wire logic clk,
	input wire logic arst_n,
	pts_req_if.sink  req,
	pts_res_if.source res,
	pts_cfg_if.sink  cfg
);
	import pts_pkg::*;

	localparam int AW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
	localparam int CW = $clog2(TABLE_SIZE + 1);
	localparam int EW = $bits(entry_t);

	typedef enum logic [3:0] {
		S_IDLE, S_DIV, S_CR_RD, S_CR_EX, S_CR_WR,
		S_DEL_RD, S_DEL_EX, S_TK_RD, S_TK_EX, S_RESP
	} state_t;

	state_t            state_q;
	logic              enabled_q;
	logic [7:0]        tick_res_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     total_q;
	logic [TABLE_SIZE:0] map_q;
	logic [7:0]        presc_q;
	logic [ID_W-1:0]   id_q;
	logic [LAP_W-1:0]  lap_q;
	logic              os_q;
	logic [PRI_W-1:0]  pri_q;
	logic [CW-1:0]     i_q;
	logic [CW-1:0]     w_q;
	logic [CW-1:0]     pos_q;
	logic              found_q;
	logic [REPORT_W-1:0] n_q;
	logic              pend_valid_q;
	logic [ID_W-1:0]   pend_id_q;
	logic [1:0]        status_q;

	logic              out_valid_q;
	logic [1:0]        out_status_q;
	logic              out_fired_q;
	logic [ID_W-1:0]   out_id_q;
	logic              out_last_q;

	logic              div_start;
	logic              div_done;
	logic [LAP_W-1:0]  div_quot;
	logic [LAP_W-1:0]  div_rem;

	logic              ram_wr_en;
	logic [AW-1:0]     ram_wr_addr;
	entry_t            ram_wr_data;
	logic              ram_rd_en;
	logic [AW-1:0]     ram_rd_addr;
	logic [EW-1:0]     ram_rd_raw;
	entry_t            rd_ent;
	entry_t            new_ent;
	entry_t            tick_ent;

	logic [7:0]        res_w;
	logic [7:0]        presc_inc;
	logic              accept;
	logic [ID_W-1:0]   id_sel;
	logic              id_ok;
	logic              taken;
	logic              create_bad;
	logic              out_free;
	logic [CNT_W-1:0]  new_tick;
	logic              hit;
	logic              drop;
	logic              report;
	logic              need_out;
	logic              stall;
	logic              fid_ok;
	logic              more;
	logic              del_match;
	logic              emit;
	logic [1:0]        emit_status;
	logic              emit_fired;
	logic [ID_W-1:0]   emit_id;
	logic              emit_last;

	pts_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (req.period_ms),
		.divisor   (res_w),
		.done      (div_done),
		.quotient  (div_quot),
		.remainder (div_rem)
	);

	pts_ram #(
		.WIDTH (EW),
		.DEPTH (TABLE_SIZE),
		.AW    (AW)
	) u_table (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_raw)
	);

	assign rd_ent    = entry_t'(ram_rd_raw);
	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign accept    = req.valid && (state_q == S_IDLE);
	assign out_free  = !out_valid_q || res.ready;

	always_comb begin
		res_w     = (tick_res_q == 8'd0) ? 8'd1 : tick_res_q;
		presc_inc = presc_q + 8'd1;
		id_sel    = (state_q == S_IDLE) ? req.task_id : id_q;
		id_ok     = 32'(id_sel) <= TABLE_SIZE;
		taken     = id_ok && map_q[CW'(id_sel)];
		create_bad = !id_ok || taken || (32'(lap_q) > MAX_LAP) || (div_rem != '0)
			|| (count_q >= CW'(TABLE_SIZE));
		div_start = accept && enabled_q && (req.req_type == REQ_CREATE);

		new_tick  = rd_ent.tick_count + 8'd1;
		hit       = new_tick == rd_ent.fire_count;
		drop      = hit && rd_ent.single_run;
		report    = hit && (n_q < REPORT_W'(RESULT_CAP));
		need_out  = report && pend_valid_q;
		stall     = need_out && !out_free;
		fid_ok    = 32'(rd_ent.id) <= TABLE_SIZE;
		del_match = !found_q && (rd_ent.id == id_q);

		tick_ent            = rd_ent;
		tick_ent.tick_count = hit ? '0 : new_tick;

		new_ent.id           = id_q;
		new_ent.fire_count   = div_quot;
		new_ent.tick_count   = '0;
		new_ent.priority_val = pri_q;
		new_ent.single_run   = os_q;

		if (state_q == S_TK_EX) begin
			more = (i_q + 1'b1) < total_q;
		end else begin
			more = (i_q + 1'b1) < count_q;
		end
	end

	// table RAM access
	always_comb begin
		ram_wr_en   = 1'b0;
		ram_wr_addr = '0;
		ram_wr_data = rd_ent;
		ram_rd_en   = 1'b0;
		ram_rd_addr = i_q[AW-1:0];
		case (state_q)
			S_CR_RD, S_DEL_RD, S_TK_RD: begin
				ram_rd_en = 1'b1;
			end
			S_CR_EX: begin
				if (rd_ent.priority_val >= pri_q) begin
					ram_wr_en   = 1'b1;
					ram_wr_addr = AW'(i_q + 1'b1);
					if (i_q != '0) begin
						ram_rd_en   = 1'b1;
						ram_rd_addr = AW'(i_q - 1'b1);
					end
				end
			end
			S_CR_WR: begin
				ram_wr_en   = 1'b1;
				ram_wr_addr = pos_q[AW-1:0];
				ram_wr_data = new_ent;
			end
			S_DEL_EX: begin
				ram_wr_en   = found_q;
				ram_wr_addr = AW'(i_q - 1'b1);
				ram_rd_en   = more;
				ram_rd_addr = AW'(i_q + 1'b1);
			end
			S_TK_EX: begin
				ram_wr_en   = !stall && !drop;
				ram_wr_addr = w_q[AW-1:0];
				ram_wr_data = tick_ent;
				ram_rd_en   = !stall && more;
				ram_rd_addr = AW'(i_q + 1'b1);
			end
			default: begin
			end
		endcase
	end

	// result register load
	always_comb begin
		emit        = 1'b0;
		emit_status = ST_OK;
		emit_fired  = 1'b0;
		emit_id     = '0;
		emit_last   = 1'b0;
		case (state_q)
			S_TK_EX: begin
				emit       = need_out && out_free;
				emit_fired = 1'b1;
				emit_id    = pend_id_q;
			end
			S_RESP: begin
				emit        = out_free;
				emit_status = status_q;
				emit_fired  = pend_valid_q;
				emit_id     = pend_valid_q ? pend_id_q : '0;
				emit_last   = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			enabled_q    <= 1'b0;
			tick_res_q   <= 8'd1;
			count_q      <= '0;
			total_q      <= '0;
			map_q        <= '0;
			presc_q      <= '0;
			i_q          <= '0;
			w_q          <= '0;
			pos_q        <= '0;
			found_q      <= 1'b0;
			n_q          <= '0;
			pend_valid_q <= 1'b0;
			pend_id_q    <= '0;
			status_q     <= ST_OK;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg.valid) begin
				case (cfg.index)
					REG_ENABLED:  enabled_q  <= cfg.data[0];
					REG_TICK_RES: tick_res_q <= cfg.data;
					default: begin
					end
				endcase
			end

			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						pend_valid_q <= 1'b0;
						if (!enabled_q) begin
							status_q <= ST_NOT_INIT;
							state_q  <= S_RESP;
						end else begin
							case (req.req_type)
								REQ_TICK: begin
									status_q <= ST_OK;
									if (presc_inc >= res_w) begin
										presc_q <= '0;
										i_q     <= '0;
										w_q     <= '0;
										n_q     <= '0;
										total_q <= count_q;
										if (count_q != '0) begin
											state_q <= S_TK_RD;
										end else begin
											state_q <= S_RESP;
										end
									end else begin
										presc_q <= presc_inc;
										state_q <= S_RESP;
									end
								end
								REQ_CREATE: begin
									status_q <= ST_OK;
									state_q  <= S_DIV;
								end
								REQ_DELETE: begin
									if (!taken) begin
										status_q <= ST_INVALID;
										state_q  <= S_RESP;
									end else begin
										status_q <= ST_OK;
										map_q[CW'(req.task_id)] <= 1'b0;
										i_q     <= '0;
										found_q <= 1'b0;
										if (count_q != '0) begin
											state_q <= S_DEL_RD;
										end else begin
											state_q <= S_RESP;
										end
									end
								end
								default: begin
									status_q <= ST_INVALID;
									state_q  <= S_RESP;
								end
							endcase
						end
					end
				end
				S_DIV: begin
					if (div_done) begin
						if (create_bad) begin
							status_q <= ST_INVALID;
							state_q  <= S_RESP;
						end else begin
							map_q[CW'(id_q)] <= 1'b1;
							if (count_q == '0) begin
								pos_q   <= '0;
								state_q <= S_CR_WR;
							end else begin
								i_q     <= count_q - 1'b1;
								state_q <= S_CR_RD;
							end
						end
					end
				end
				S_CR_RD: begin
					state_q <= S_CR_EX;
				end
				S_CR_EX: begin
					if (rd_ent.priority_val >= pri_q) begin
						if (i_q == '0) begin
							pos_q   <= '0;
							state_q <= S_CR_WR;
						end else begin
							i_q <= i_q - 1'b1;
						end
					end else begin
						pos_q   <= i_q + 1'b1;
						state_q <= S_CR_WR;
					end
				end
				S_CR_WR: begin
					count_q <= count_q + 1'b1;
					state_q <= S_RESP;
				end
				S_DEL_RD: begin
					state_q <= S_DEL_EX;
				end
				S_DEL_EX: begin
					if (del_match) begin
						found_q <= 1'b1;
					end
					if (more) begin
						i_q <= i_q + 1'b1;
					end else begin
						if (found_q || del_match) begin
							count_q <= count_q - 1'b1;
						end
						state_q <= S_RESP;
					end
				end
				S_TK_RD: begin
					state_q <= S_TK_EX;
				end
				S_TK_EX: begin
					if (!stall) begin
						if (report) begin
							pend_valid_q <= 1'b1;
							pend_id_q    <= rd_ent.id;
							n_q          <= n_q + 1'b1;
						end
						if (drop) begin
							count_q <= count_q - 1'b1;
							if (fid_ok) begin
								map_q[CW'(rd_ent.id)] <= 1'b0;
							end
						end else begin
							w_q <= w_q + 1'b1;
						end
						if (more) begin
							i_q <= i_q + 1'b1;
						end else begin
							state_q <= S_RESP;
						end
					end
				end
				S_RESP: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			id_q  <= req.task_id;
			lap_q <= req.period_ms;
			os_q  <= req.single_run;
			pri_q <= req.priority_req;
		end
		if (emit) begin
			out_status_q <= emit_status;
			out_fired_q  <= emit_fired;
			out_id_q     <= emit_id;
			out_last_q   <= emit_last;
		end
	end

	assign res.valid         = out_valid_q;
	assign res.status        = out_status_q;
	assign res.fired         = out_fired_q;
	assign res.fired_task_id = out_id_q;
	assign res.last          = out_last_q;

endmodule
`default_nettype wire

FILE: verif/tb_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the priority tick task scheduler. A shadow copy of the task
// table predicts every result of each accepted request: status of create,
// delete and rejected requests, and the firing reports of scheduler ticks in
// table order. Directed tests cover the disabled unit, parameter checks,
// one-shot removal, equal priorities, a full table, zero resolution and one
// long result back-pressure stretch; random phases follow with several
// register settings and random gaps on both channels.
// ----------------------------------------------------------------------------
module tb_top;
	import pts_pkg::*;

	localparam int TABLE_SIZE    = 8;
	localparam int MAX_LAP       = 255;
	localparam int IDLE_LIMIT    = 2000;
	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_CYCLES   = 300;
	localparam logic [1:0] REQ_UNKNOWN = 2'd3;

	typedef struct packed {
		logic [1:0]       req_type;
		logic [ID_W-1:0]  task_id;
		logic [LAP_W-1:0] period_ms;
		logic             single_run;
		logic [PRI_W-1:0] priority_req;
	} sched_req_t;

	typedef struct packed {
		logic [1:0]      status;
		logic            fired;
		logic [ID_W-1:0] fired_task_id;
		logic            last;
	} sched_res_t;

	logic clk;
	logic arst_n;

	pts_req_if req_ch();
	pts_res_if res_ch();
	pts_cfg_if cfg_ch();

	priority_tick_task_scheduler_unit #(
		.TABLE_SIZE(TABLE_SIZE),
		.MAX_LAP(MAX_LAP)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.res(res_ch),
		.cfg(cfg_ch)
	);

	// shadow copy of the scheduler state
	entry_t                  shadow_tbl[TABLE_SIZE];
	int                      shadow_n     = 0;
	logic [TABLE_SIZE:0]     shadow_ids   = '0;
	logic [CNT_W-1:0]        shadow_presc = '0;
	logic                    shadow_en    = 1'b0;
	logic [CFG_DATA_W-1:0]   shadow_res   = 8'd1;

	sched_res_t pending_results[$];
	int         err_cnt      = 0;
	bit         idle_on      = 1'b1;
	bit         hold_trigger = 1'b0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!idle_on || r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic int eff_res();
		return (shadow_res == '0) ? 1 : int'(shadow_res);
	endfunction

	function automatic sched_req_t mk_req(input logic [1:0] kind, input int id, input int lap,
		input bit os, input int pri);
		sched_req_t rq;
		rq.req_type     = kind;
		rq.task_id      = ID_W'(id);
		rq.period_ms    = LAP_W'(lap);
		rq.single_run   = os;
		rq.priority_req = PRI_W'(pri);
		return rq;
	endfunction

	function automatic void push_result(input logic [1:0] st, input logic f,
		input logic [ID_W-1:0] id, input logic lst);
		sched_res_t r;
		r.status        = st;
		r.fired         = f;
		r.fired_task_id = id;
		r.last          = lst;
		pending_results.push_back(r);
	endfunction

	function automatic void drop_entry(input int pos);
		for (int i = pos; i + 1 < shadow_n; i++) shadow_tbl[i] = shadow_tbl[i + 1];
		shadow_n--;
	endfunction

	function automatic logic [1:0] create_entry(input sched_req_t rq);
		int resv;
		int pos;
		resv = eff_res();
		if (rq.task_id > TABLE_SIZE) return ST_INVALID;
		if (shadow_ids[rq.task_id]) return ST_INVALID;
		if (int'(rq.period_ms) > MAX_LAP || (int'(rq.period_ms) % resv) != 0) return ST_INVALID;
		if (shadow_n >= TABLE_SIZE) return ST_INVALID;
		pos = shadow_n;
		for (int i = 0; i < shadow_n; i++) begin
			if (shadow_tbl[i].priority_val >= rq.priority_req) begin
				pos = i;
				break;
			end
		end
		for (int i = shadow_n; i > pos; i--) shadow_tbl[i] = shadow_tbl[i - 1];
		shadow_tbl[pos].id           = rq.task_id;
		shadow_tbl[pos].fire_count   = CNT_W'(int'(rq.period_ms) / resv);
		shadow_tbl[pos].tick_count   = '0;
		shadow_tbl[pos].priority_val = rq.priority_req;
		shadow_tbl[pos].single_run   = rq.single_run;
		shadow_n++;
		shadow_ids[rq.task_id] = 1'b1;
		return ST_OK;
	endfunction

	function automatic logic [1:0] delete_entry(input logic [ID_W-1:0] id);
		if (id > TABLE_SIZE) return ST_INVALID;
		if (!shadow_ids[id]) return ST_INVALID;
		for (int i = 0; i < shadow_n; i++) begin
			if (shadow_tbl[i].id == id) begin
				drop_entry(i);
				break;
			end
		end
		shadow_ids[id] = 1'b0;
		return ST_OK;
	endfunction

	// expected results of one accepted request, applied to the shadow table
	function automatic void apply_request(input sched_req_t rq);
		sched_res_t      hits[RESULT_CAP];
		int              n;
		int              i;
		logic [ID_W-1:0] fid;
		n = 0;
		if (!shadow_en) begin
			push_result(ST_NOT_INIT, 1'b0, '0, 1'b1);
		end else if (rq.req_type == REQ_CREATE) begin
			push_result(create_entry(rq), 1'b0, '0, 1'b1);
		end else if (rq.req_type == REQ_DELETE) begin
			push_result(delete_entry(rq.task_id), 1'b0, '0, 1'b1);
		end else if (rq.req_type != REQ_TICK) begin
			push_result(ST_INVALID, 1'b0, '0, 1'b1);
		end else begin
			shadow_presc = shadow_presc + 8'd1;
			if (int'(shadow_presc) >= eff_res()) begin
				shadow_presc = '0;
				i = 0;
				while (i < shadow_n) begin
					shadow_tbl[i].tick_count = shadow_tbl[i].tick_count + 8'd1;
					if (shadow_tbl[i].tick_count == shadow_tbl[i].fire_count) begin
						fid = shadow_tbl[i].id;
						shadow_tbl[i].tick_count = '0;
						if (n < RESULT_CAP) begin
							hits[n].status        = ST_OK;
							hits[n].fired         = 1'b1;
							hits[n].fired_task_id = fid;
							hits[n].last          = 1'b0;
							n++;
						end
						if (shadow_tbl[i].single_run) begin
							drop_entry(i);
							shadow_ids[fid] = 1'b0;
							continue;
						end
					end
					i++;
				end
			end
			if (n == 0) begin
				push_result(ST_OK, 1'b0, '0, 1'b1);
			end else begin
				hits[n - 1].last = 1'b1;
				for (int k = 0; k < n; k++) pending_results.push_back(hits[k]);
			end
		end
	endfunction

	// valid stays high after a transaction until the next gap or idle_req
	task automatic send_req(input sched_req_t rq);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid        <= 1'b1;
		req_ch.req_type     <= rq.req_type;
		req_ch.task_id      <= rq.task_id;
		req_ch.period_ms    <= rq.period_ms;
		req_ch.single_run   <= rq.single_run;
		req_ch.priority_req <= rq.priority_req;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		apply_request(rq);
	endtask

	task automatic idle_req();
		req_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain_results();
		idle_req();
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= CFG_DATA_W'(value);
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		if (idx == REG_ENABLED) shadow_en = value[0];
		else shadow_res = CFG_DATA_W'(value);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic sched_req_t random_req();
		sched_req_t rq;
		int r;
		int kmax;
		int k;
		r    = $urandom_range(0, 99);
		kmax = MAX_LAP / eff_res();
		rq   = mk_req(REQ_TICK, $urandom_range(0, TABLE_SIZE), 0, 1'($urandom_range(0, 1)),
			$urandom_range(0, 255));
		if (r < 40) begin
			rq.period_ms = LAP_W'($urandom_range(0, 255));
		end else if (r < 68) begin
			rq.req_type = REQ_CREATE;
			if ($urandom_range(0, 4) == 0) k = $urandom_range(0, kmax);
			else k = $urandom_range(1, (kmax < 3) ? kmax : 3);
			rq.period_ms = LAP_W'(k * eff_res());
		end else if (r < 88) begin
			rq.req_type = REQ_DELETE;
		end else begin
			rq.req_type  = 2'($urandom_range(0, 3));
			rq.task_id   = ID_W'($urandom_range(0, 15));
			rq.period_ms = LAP_W'($urandom_range(0, 255));
		end
		return rq;
	endfunction

	task automatic test_disabled();
		send_req(mk_req(REQ_TICK, 0, 0, 0, 0));
		send_req(mk_req(REQ_CREATE, 1, 1, 0, 10));
		send_req(mk_req(REQ_DELETE, 1, 0, 0, 0));
		send_req(mk_req(REQ_UNKNOWN, 15, 255, 1, 255));
		drain_results();
		write_reg(REG_ENABLED, 1);
		write_reg(REG_TICK_RES, 1);
	endtask

	task automatic test_create_delete();
		send_req(mk_req(REQ_UNKNOWN, 0, 0, 0, 0));
		send_req(mk_req(REQ_CREATE, 15, 255, 1, 255));
		send_req(mk_req(REQ_CREATE, 0, 1, 1, 200));
		send_req(mk_req(REQ_CREATE, 8, 1, 0, 255));
		send_req(mk_req(REQ_CREATE, 8, 2, 0, 3));
		send_req(mk_req(REQ_CREATE, 3, 2, 0, 0));
		send_req(mk_req(REQ_DELETE, 9, 0, 0, 0));
		send_req(mk_req(REQ_DELETE, 4, 0, 0, 0));
	endtask

	task automatic test_firing();
		// one-shot entry removed ahead of a firing entry
		send_req(mk_req(REQ_TICK, 0, 0, 0, 0));
		send_req(mk_req(REQ_TICK, 0, 0, 0, 0));
		send_req(mk_req(REQ_DELETE, 0, 0, 0, 0));
		send_req(mk_req(REQ_DELETE, 8, 0, 0, 0));
		send_req(mk_req(REQ_CREATE, 5, 0, 0, 128));
		drain_results();
		write_reg(REG_TICK_RES, 3);
		send_req(mk_req(REQ_CREATE, 6, 4, 0, 128));
		send_req(mk_req(REQ_CREATE, 6, 255, 0, 128));
		send_req(mk_req(REQ_TICK, 0, 0, 0, 0));
		drain_results();
		write_reg(REG_TICK_RES, 0);
		send_req(mk_req(REQ_TICK, 0, 0, 0, 0));
	endtask

	task automatic test_table_full();
		send_req(mk_req(REQ_CREATE, 0, 0, 0, 7));
		send_req(mk_req(REQ_CREATE, 1, 1, 1, 128));
		send_req(mk_req(REQ_CREATE, 2, 2, 0, 255));
		send_req(mk_req(REQ_CREATE, 4, 1, 0, 0));
		send_req(mk_req(REQ_CREATE, 7, 1, 1, 64));
		send_req(mk_req(REQ_CREATE, 8, 1, 0, 1));
		drain_results();
	endtask

	task automatic test_backpressure();
		write_reg(REG_TICK_RES, 1);
		for (int id = 0; id <= TABLE_SIZE; id++) send_req(mk_req(REQ_DELETE, id, 0, 0, 0));
		for (int id = 0; id < TABLE_SIZE; id++) send_req(mk_req(REQ_CREATE, id, 1, 0, id));
		drain_results();
		idle_on      = 1'b0;
		hold_trigger = 1'b1;
		for (int k = 0; k < 20; k++) send_req(mk_req(REQ_TICK, 0, 0, 0, 0));
		drain_results();
		idle_on = 1'b1;
	endtask

	task automatic test_random();
		int res_list[8];
		int count;
		res_list = '{1, 2, 1, 255, 1, 3, 0, 5};
		for (int p = 0; p < 8; p++) begin
			drain_results();
			write_reg(REG_ENABLED, (p == 5) ? 0 : 1);
			write_reg(REG_TICK_RES, res_list[p]);
			idle_on = p[0];
			count   = (p == 5) ? 8 : 21;
			for (int k = 0; k < count; k++) send_req(random_req());
		end
		drain_results();
		idle_on = 1'b1;
	endtask

	// result checker and receiver idling
	initial begin : result_sink
		int         stall_left;
		int         hold_left;
		sched_res_t want;
		stall_left = 0;
		hold_left  = 0;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
				if (pending_results.size() == 0) begin
					err_cnt++;
					$display("%0t: unexpected result: actual status %0d fired %0d id %0d last %0d",
						$time, res_ch.status, res_ch.fired, res_ch.fired_task_id, res_ch.last);
				end else begin
					want = pending_results.pop_front();
					if (res_ch.status !== want.status || res_ch.fired !== want.fired ||
						res_ch.fired_task_id !== want.fired_task_id ||
						res_ch.last !== want.last) begin
						err_cnt++;
						$display("%0t: result mismatch: expected status %0d fired %0d id %0d last %0d",
							$time, want.status, want.fired, want.fired_task_id, want.last);
						$display("%0t:                  actual status %0d fired %0d id %0d last %0d",
							$time, res_ch.status, res_ch.fired, res_ch.fired_task_id, res_ch.last);
					end
				end
			end
			if (hold_trigger) begin
				hold_trigger = 1'b0;
				hold_left    = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
				stall_left = pick_gap();
			end
		end
	end

	// cycles without any transaction
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < IDLE_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
				(res_ch.valid === 1'b1 && res_ch.ready === 1'b1) ||
				(cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("%0t: timeout, %0d results still pending", $time, pending_results.size());
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		req_ch.valid        <= 1'b0;
		req_ch.req_type     <= REQ_TICK;
		req_ch.task_id      <= '0;
		req_ch.period_ms    <= '0;
		req_ch.single_run   <= 1'b0;
		req_ch.priority_req <= '0;
		cfg_ch.valid        <= 1'b0;
		cfg_ch.index        <= REG_ENABLED;
		cfg_ch.data         <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_disabled();
		test_create_delete();
		test_firing();
		test_table_full();
		test_backpressure();
		test_random();
		drain_results();
		if (err_cnt == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
`default_nettype wire

FILE: filelist.f
src/pts_pkg.sv
src/pts_if.sv
src/pts_ram.sv
src/pts_div.sv
src/priority_tick_task_scheduler_unit.sv
verif/tb_top.sv
